FILE: design/assert_macros.svh
// Assertion helpers. Both sample on the rising edge of clk and are switched
// off while rst_n is low, so the module that uses them must have those names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define TFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define TFD_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/tfd_pkg.sv
package tfd_pkg;

  localparam int COUNT_W = 21;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 21'd1024;

  typedef enum logic [0:0] {
    REG_FORMAT = 1'b0,
    REG_COUNT  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    FMT_RGBA16 = 3'd0,
    FMT_RGBA32 = 3'd1,
    FMT_IA16   = 3'd2,
    FMT_IA8    = 3'd3,
    FMT_IA4    = 3'd4,
    FMT_IA1    = 3'd5,
    FMT_I8     = 3'd6,
    FMT_I4     = 3'd7
  } fmt_t;

  typedef struct packed {
    fmt_t               mode;
    logic [COUNT_W-1:0] pixel_count;
    logic               restart;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  // floor(v * 255 / 31) equals 8v plus a correction of 0..7 that steps up at
  // fixed thresholds of v.
  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [2:0] corr;
    corr = 3'(v >= 5'd5) + 3'(v >= 5'd9) + 3'(v >= 5'd14) + 3'(v >= 5'd18)
         + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v >= 5'd31);
    return {v, 3'b000} + {5'b00000, corr};
  endfunction

  function automatic logic [7:0] widen4(input logic [3:0] v);
    return {v, v};
  endfunction

  function automatic logic [7:0] widen3(input logic [2:0] v);
    return {v, v, 2'b00};
  endfunction

endpackage

FILE: design/tfd_cfg.sv
module tfd_cfg
  import tfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg
);

  fmt_t               mode_r;
  logic [COUNT_W-1:0] count_r;
  reg_idx_t           idx;
  logic               wr;

  assign idx        = reg_idx_t'(cfg_paddr[2]);
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= FMT_RGBA16;
      count_r <= COUNT_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_FORMAT: mode_r  <= fmt_t'(cfg_pwdata[2:0]);
        REG_COUNT:  count_r <= cfg_pwdata[COUNT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FORMAT: cfg_prdata = {29'd0, mode_r};
      REG_COUNT:  cfg_prdata = {{(32-COUNT_W){1'b0}}, count_r};
      default:    cfg_prdata = '0;
    endcase
  end

  assign cfg.mode        = mode_r;
  assign cfg.pixel_count = count_r;
  assign cfg.restart     = wr && (idx == REG_FORMAT);

endmodule

FILE: design/tfd_pix.sv
module tfd_pix
  import tfd_pkg::*;
(
  input  fmt_t        mode,
  input  logic [7:0]  raw,
  input  logic [23:0] held,
  input  logic [2:0]  sel,
  output pixel_t      pix
);

  logic [3:0] nib;
  logic       bit1;
  logic [7:0] iv;

  assign nib  = sel[0] ? raw[3:0] : raw[7:4];
  assign bit1 = raw[3'd7 - sel];

  always_comb begin
    iv = 8'd0;
    pix = '0;
    unique case (mode)
      FMT_RGBA16: begin
        pix.red   = widen5(held[7:3]);
        pix.green = widen5({held[2:0], raw[7:6]});
        pix.blue  = widen5(raw[5:1]);
        pix.alpha = raw[0] ? 8'hFF : 8'h00;
      end
      FMT_RGBA32: begin
        pix.red   = held[23:16];
        pix.green = held[15:8];
        pix.blue  = held[7:0];
        pix.alpha = raw;
      end
      FMT_IA16: begin
        iv        = held[7:0];
        pix       = '{iv, iv, iv, raw};
      end
      FMT_IA8: begin
        iv        = widen4(raw[7:4]);
        pix       = '{iv, iv, iv, widen4(raw[3:0])};
      end
      FMT_IA4: begin
        iv        = widen3(nib[3:1]);
        pix       = '{iv, iv, iv, (nib[0] ? 8'hFF : 8'h00)};
      end
      FMT_IA1: begin
        iv        = bit1 ? 8'hFF : 8'h00;
        pix       = '{iv, iv, iv, iv};
      end
      FMT_I8: begin
        pix       = '{raw, raw, raw, 8'hFF};
      end
      FMT_I4: begin
        iv        = widen4(nib);
        pix       = '{iv, iv, iv, 8'hFF};
      end
      default: pix = '0;
    endcase
  end

endmodule

FILE: design/texel_format_decoder.sv
// Texel format decoder: takes one packed texture byte per input beat and
// gives 8-bit RGBA pixels, one per output beat, in the format chosen by the
// format register. A byte is registered with its pixel count in the job
// register, and a single output register then moves out one pixel per
// cycle from it while out_stall is low. One-pixel formats sustain one
// byte per cycle while the output is not stalled; IA 4 and I 4 yield two
// pixels per byte and IA 1 eight, and such a byte holds the input until
// its pixels have moved out through that one pixel-wide output register.
// Bytes that only complete part of a pixel, and bytes arriving after the
// image is finished, give no pixel and take no output slot of their own,
// but like any byte they wait while earlier pixels remain to move out.
`include "assert_macros.svh"

module texel_format_decoder
  import tfd_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = 1048576
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_raw_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        out_last_from_byte,
  output logic        out_image_done
);

  localparam int MaxW = $clog2(MAX_PIXELS + 1);
  localparam int CmpW = (MaxW > COUNT_W) ? MaxW : COUNT_W;
  localparam logic [CmpW-1:0] MaxPix = CmpW'(MAX_PIXELS);

  cfg_t cfg;

  logic [1:0]         phase_r, phase_nxt;
  logic [23:0]        held_r, held_nxt;
  logic [COUNT_W-1:0] idx_r;

  logic               job_valid_r;
  fmt_t               job_mode_r;
  logic [7:0]         job_byte_r;
  logic [23:0]        job_held_r;
  logic [3:0]         job_emit_r;
  logic               job_done_r;
  logic [2:0]         pix_k_r;

  logic               out_valid_r;
  pixel_t             out_pix_r;
  logic               out_last_r;
  logic               out_done_r;

  logic [COUNT_W-1:0] limit;
  logic [COUNT_W-1:0] remaining;
  logic               active;
  logic [3:0]         n_pix;
  logic [3:0]         emit;
  logic               in_accept;
  logic               take;
  logic               new_job;
  logic               out_free;
  logic               job_last;
  logic               advance;
  pixel_t             pix;

  tfd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign limit     = (CmpW'(cfg.pixel_count) > MaxPix) ? MaxPix[COUNT_W-1:0]
                                                       : cfg.pixel_count;
  assign active    = idx_r < limit;
  assign remaining = limit - idx_r;

  always_comb begin
    n_pix     = 4'd0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    unique case (cfg.mode)
      FMT_RGBA16, FMT_IA16: begin
        if (phase_r == 2'd0) begin
          held_nxt  = {16'd0, in_raw_byte};
          phase_nxt = 2'd1;
        end else begin
          n_pix     = 4'd1;
          held_nxt  = '0;
          phase_nxt = 2'd0;
        end
      end
      FMT_RGBA32: begin
        if (phase_r != 2'd3) begin
          held_nxt  = {held_r[15:0], in_raw_byte};
          phase_nxt = phase_r + 2'd1;
        end else begin
          n_pix     = 4'd1;
          held_nxt  = '0;
          phase_nxt = 2'd0;
        end
      end
      FMT_IA4, FMT_I4: n_pix = 4'd2;
      FMT_IA1:         n_pix = 4'd8;
      FMT_IA8, FMT_I8: n_pix = 4'd1;
      default:         n_pix = 4'd0;
    endcase
  end

  assign emit = (remaining < COUNT_W'(n_pix)) ? remaining[3:0] : n_pix;

  assign out_free  = !out_valid_r || !out_stall;
  assign job_last  = ({1'b0, pix_k_r} + 4'd1) == job_emit_r;
  assign advance   = job_valid_r && out_free;
  assign in_stall  = job_valid_r && !(out_free && job_last);
  assign in_accept = in_valid && !in_stall;
  assign take      = in_accept && active;
  assign new_job   = take && (n_pix != 4'd0);

  always_ff @(posedge clk) begin
    if (!rst_n || cfg.restart) begin
      phase_r <= 2'd0;
      held_r  <= '0;
      idx_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      idx_r   <= idx_r + COUNT_W'(emit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else if (new_job) begin
      job_valid_r <= 1'b1;
    end else if (advance && job_last) begin
      job_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (new_job) begin
      job_mode_r <= cfg.mode;
      job_byte_r <= in_raw_byte;
      job_held_r <= held_r;
      job_emit_r <= emit;
      job_done_r <= remaining <= COUNT_W'(n_pix);
      pix_k_r    <= 3'd0;
    end else if (advance) begin
      pix_k_r    <= pix_k_r + 3'd1;
    end
  end

  tfd_pix u_pix (
    .mode (job_mode_r),
    .raw  (job_byte_r),
    .held (job_held_r),
    .sel  (pix_k_r),
    .pix  (pix)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= job_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pix_r  <= pix;
      out_last_r <= job_last;
      out_done_r <= job_last && job_done_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_red            = out_pix_r.red;
  assign out_green          = out_pix_r.green;
  assign out_blue           = out_pix_r.blue;
  assign out_alpha          = out_pix_r.alpha;
  assign out_last_from_byte = out_last_r;
  assign out_image_done     = out_done_r;

  `TFD_ASSERT_NEVER(a_job_empty, job_valid_r && (job_emit_r == 4'd0), "Held byte has no pixels.")
  `TFD_ASSERT(a_sel_range, job_valid_r |-> ({1'b0, pix_k_r} < job_emit_r), "Pixel select overran.")
  `TFD_ASSERT(a_done_last, (out_valid_r && out_done_r) |-> out_last_r, "Final pixel not last of byte.")
  `TFD_ASSERT(a_hold_job, (job_valid_r && !job_last) |-> in_stall, "Byte taken over a busy one.")

endmodule
